/* rtl/core/ami_pkg.sv */
// Shared types, constants and the inversion sequence table for the affine inverse core.
// No dependencies; used by ami_ctrl, ami_dp and affine_matrix_inverse_core.
package ami_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int NUM_UOPS  = 39;
    localparam int UOP_W     = 6;
    localparam int ACC_W     = DATA_W + 3;
    localparam int NUM_W     = (2 * FRAC_BITS + 2 > 33) ? 2 * FRAC_BITS + 2 : 33;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    localparam logic [UOP_W-1:0] LAST_P1  = UOP_W'(20);
    localparam logic [UOP_W-1:0] FIRST_P2 = UOP_W'(21);
    localparam logic [UOP_W-1:0] LAST_UOP = UOP_W'(NUM_UOPS - 1);
    localparam logic [ADDR_W-1:0] INV_ADDR = 5'd19;
    localparam logic [3:0] LAST_INDEX = 4'd15;

    typedef struct packed {
        logic [3:0]        element_index;
        logic signed [31:0] element_value;
        logic              final_element;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        out_index;
        logic signed [31:0] out_value;
        logic              singular;
        logic              last;
    } out_item_t;

    // one product step: acc = (clr ? 0 : acc) +/- round(a*b), optional writeback
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              clr;
        logic              neg;
        logic              wr;
        logic [ADDR_W-1:0] dst;
    } uop_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_CHK,
        S_DIV,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              load_we;
        uop_t              uop;
        logic              acc_en;
        logic              chk;
        logic              div_start;
        logic              inv_wr;
        logic              emit_sel;
        logic [3:0]        emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic sing;
        logic div_done;
    } dp_stat_t;

    // scratch layout: 0..15 matrix, 16+i result i; det and reciprocal share slot 19
    localparam uop_t UOP_TABLE [NUM_UOPS] = '{
        '{5'd5,  5'd10, 1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd6,  5'd9,  1'b0, 1'b1, 1'b1, 5'd16},
        '{5'd2,  5'd9,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd1,  5'd10, 1'b0, 1'b1, 1'b1, 5'd17},
        '{5'd1,  5'd6,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd2,  5'd5,  1'b0, 1'b1, 1'b1, 5'd18},
        '{5'd6,  5'd8,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd4,  5'd10, 1'b0, 1'b1, 1'b1, 5'd20},
        '{5'd0,  5'd10, 1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd2,  5'd8,  1'b0, 1'b1, 1'b1, 5'd21},
        '{5'd2,  5'd4,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd6,  1'b0, 1'b1, 1'b1, 5'd22},
        '{5'd4,  5'd9,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd5,  5'd8,  1'b0, 1'b1, 1'b1, 5'd24},
        '{5'd1,  5'd8,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd0,  5'd9,  1'b0, 1'b1, 1'b1, 5'd25},
        '{5'd0,  5'd5,  1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd1,  5'd4,  1'b0, 1'b1, 1'b1, 5'd26},
        '{5'd0,  5'd16, 1'b1, 1'b0, 1'b0, 5'd0},
        '{5'd4,  5'd17, 1'b0, 1'b0, 1'b0, 5'd0},
        '{5'd8,  5'd18, 1'b0, 1'b0, 1'b1, 5'd19},
        '{5'd19, 5'd16, 1'b1, 1'b0, 1'b1, 5'd16},
        '{5'd19, 5'd17, 1'b1, 1'b0, 1'b1, 5'd17},
        '{5'd19, 5'd18, 1'b1, 1'b0, 1'b1, 5'd18},
        '{5'd19, 5'd20, 1'b1, 1'b0, 1'b1, 5'd20},
        '{5'd19, 5'd21, 1'b1, 1'b0, 1'b1, 5'd21},
        '{5'd19, 5'd22, 1'b1, 1'b0, 1'b1, 5'd22},
        '{5'd19, 5'd24, 1'b1, 1'b0, 1'b1, 5'd24},
        '{5'd19, 5'd25, 1'b1, 1'b0, 1'b1, 5'd25},
        '{5'd19, 5'd26, 1'b1, 1'b0, 1'b1, 5'd26},
        '{5'd16, 5'd12, 1'b1, 1'b1, 1'b0, 5'd0},
        '{5'd20, 5'd13, 1'b0, 1'b1, 1'b0, 5'd0},
        '{5'd24, 5'd14, 1'b0, 1'b1, 1'b1, 5'd28},
        '{5'd17, 5'd12, 1'b1, 1'b1, 1'b0, 5'd0},
        '{5'd21, 5'd13, 1'b0, 1'b1, 1'b0, 5'd0},
        '{5'd25, 5'd14, 1'b0, 1'b1, 1'b1, 5'd29},
        '{5'd18, 5'd12, 1'b1, 1'b1, 1'b0, 5'd0},
        '{5'd22, 5'd13, 1'b0, 1'b1, 1'b0, 5'd0},
        '{5'd26, 5'd14, 1'b0, 1'b1, 1'b1, 5'd30}
    };

endpackage

/* rtl/core/ami_ctrl.sv */
// Sequencer for the affine inverse core: load, product steps, singularity check, divide, emit.
// Depends on ami_pkg; drives ami_dp through dp_cmd_t.
module ami_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_final,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ami_pkg::dp_stat_t stat,
    output ami_pkg::dp_cmd_t  cmd
);
    import ami_pkg::*;

    state_t            state_reg, state_next;
    logic [UOP_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]        eidx_reg, eidx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            eidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eidx_reg  <= eidx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        eidx_next  = eidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_final)
                begin
                    state_next = S_RD;
                    cnt_next   = '0;
                end
            end
            S_RD:  state_next = S_MUL;
            S_MUL: state_next = S_ACC;
            S_ACC:
            begin
                if (cnt_reg == LAST_P1)
                begin
                    state_next = S_CHK;
                end
                else if (cnt_reg == LAST_UOP)
                begin
                    state_next = S_EMIT_RD;
                    eidx_next  = '0;
                end
                else
                begin
                    state_next = S_RD;
                end
                cnt_next = (cnt_reg == LAST_UOP) ? '0 : cnt_reg + UOP_W'(1);
            end
            S_CHK:
            begin
                eidx_next  = '0;
                state_next = stat.sing ? S_EMIT_RD : S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RD;
                    cnt_next   = FIRST_P2;
                end
            end
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_ready)
                begin
                    eidx_next  = eidx_reg + 4'd1;
                    state_next = (eidx_reg == LAST_INDEX) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.uop       = UOP_TABLE[cnt_reg];
        cmd.emit_idx  = eidx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_we = in_valid;
            end
            S_ACC:     cmd.acc_en    = 1'b1;
            S_CHK:
            begin
                cmd.chk       = 1'b1;
                cmd.div_start = !stat.sing;
            end
            S_DIV:     cmd.inv_wr    = stat.div_done;
            S_EMIT_RD: cmd.emit_sel  = 1'b1;
            S_EMIT:
            begin
                cmd.emit_sel = 1'b1;
                out_valid    = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/ami_dp.sv */
// Datapath: scratch memory, shared multiplier, accumulator, reciprocal divider.
// Depends on ami_pkg; commanded by ami_ctrl.
module ami_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ami_pkg::dp_cmd_t   cmd,
    input  ami_pkg::in_item_t  in_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output ami_pkg::dp_stat_t  stat,
    output ami_pkg::out_item_t out_data
);
    import ami_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] mem [2**ADDR_W];
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [63:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic [15:0]              thr_reg;
    logic                     sing_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [32:0]              rem_reg;
    logic [31:0]              den_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;

    logic [ADDR_W-1:0]        addr_a;
    logic signed [63:0]       rnd;
    logic signed [DATA_W-1:0] p_sat;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [DATA_W-1:0] acc_sat;
    logic [31:0]              mag;
    logic [32:0]              rem_sh;
    logic                     q_bit;
    logic signed [DATA_W-1:0] inv_val;

    always_comb
    begin
        rnd = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rnd > 64'sd2147483647)
            p_sat = 32'sh7fffffff;
        else if (rnd < -64'sd2147483648)
            p_sat = 32'sh80000000;
        else
            p_sat = rnd[DATA_W-1:0];

        acc_next = (cmd.uop.clr ? ACC_W'(0) : acc_reg)
                 + (cmd.uop.neg ? -ACC_W'(p_sat) : ACC_W'(p_sat));
        if (acc_next > ACC_W'(32'sh7fffffff))
            acc_sat = 32'sh7fffffff;
        else if (acc_next < ACC_W'(32'sh80000000))
            acc_sat = 32'sh80000000;
        else
            acc_sat = acc_next[DATA_W-1:0];

        mag    = res_reg[DATA_W-1] ? 32'(-res_reg) : 32'(res_reg);
        rem_sh = {rem_reg[31:0], num_reg[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});

        if (neg_reg)
            inv_val = (num_reg > NUM_W'(33'h080000000)) ? 32'sh80000000 : 32'(-num_reg);
        else
            inv_val = (num_reg > NUM_W'(32'h7fffffff)) ? 32'sh7fffffff : 32'(num_reg);

        addr_a = cmd.emit_sel ? {1'b1, cmd.emit_idx} : cmd.uop.a;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            mem[{1'b0, in_data.element_index}] <= in_data.element_value;
        else if (cmd.acc_en && cmd.uop.wr)
            mem[cmd.uop.dst] <= acc_sat;
        else if (cmd.inv_wr)
            mem[INV_ADDR] <= inv_val;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[cmd.uop.b];
        prod_reg <= rd_a_reg * rd_b_reg;
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
            res_reg <= acc_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(mag >> 1);
            den_reg <= mag;
            neg_reg <= res_reg[DATA_W-1];
            rem_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            rem_reg <= q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 16'd1;
            sing_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (cmd.chk)
                sing_reg <= (mag <= {16'b0, thr_reg});
            if (cmd.div_start)
                dcnt_reg <= DCNT_W'(NUM_W);
            else if (dcnt_reg != '0)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_comb
    begin
        stat.sing     = (mag <= {16'b0, thr_reg});
        stat.div_done = (dcnt_reg == '0);

        out_data.out_index = cmd.emit_idx;
        out_data.singular  = sing_reg;
        out_data.last      = (cmd.emit_idx == LAST_INDEX);
        if (sing_reg)
            out_data.out_value = '0;
        else if (cmd.emit_idx == LAST_INDEX)
            out_data.out_value = ONE;
        else if (cmd.emit_idx[1:0] == 2'd3)
            out_data.out_value = '0;
        else
            out_data.out_value = rd_a_reg;
    end

endmodule

/* rtl/core/affine_matrix_inverse_core.sv */
// Affine 4x4 inverse, Q16.16: one element per cycle on load; a final request starts inversion.
// Inversion: 21 product steps, each a read, multiply and accumulate state, then a check,
// a reciprocal divide and 18 more product steps; a singular matrix skips from the check
// to output; results then leave one by one, each held until out_ready; one matrix at a time.
// Reset clears the sequencer and sets the zero threshold to 1; stored elements are not cleared.
// Depends on ami_pkg, ami_ctrl and ami_dp.
module affine_matrix_inverse_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ami_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ami_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import ami_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ami_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_final  (in_data.final_element),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ami_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .out_data    (out_data)
    );

endmodule
